FILE: src/dpsdsm_pkg.sv
// ----------------------------------------------------------------------------
// dpsdsm_pkg: shared types and constants of the servo map block
// widths, register indexes, reset values, queue depths and the payload
// structures that travel between the front, the queues and the back
// ----------------------------------------------------------------------------
package dpsdsm_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TICK_W   = 10;
  localparam int unsigned DZ_W     = 8;
  localparam int unsigned CFG_W    = 12;
  localparam int unsigned IDX_W    = 3;

  // clip times tick span, before the scale-down by the full-scale value
  localparam int unsigned PROD_W = SAMPLE_W + TICK_W;

  // divide by ten through a reciprocal, exact for every 12-bit difference
  localparam int unsigned        DIV10_MULT_W = 17;
  localparam logic [16:0]        DIV10_MULT   = 17'd52429;
  localparam int unsigned        DIV10_SHIFT  = 19;
  localparam int unsigned        DIV10_PROD_W = SAMPLE_W + DIV10_MULT_W;
  localparam int unsigned        STEP_W       = 9;

  // queue depths
  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned MID_CNT_W  = $clog2(MID_DEPTH + 1);
  localparam int unsigned OUT_DEPTH  = 8;
  localparam int unsigned OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_PWM_MIN    = 3'd0,
    REG_PWM_MAX    = 3'd1,
    REG_DZ_LOW     = 3'd2,
    REG_DZ_HIGH    = 3'd3,
    REG_FAST_LIMIT = 3'd4,
    REG_BYP_AVG    = 3'd5,
    REG_BYP_DZ     = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [TICK_W-1:0]   PWM_MIN_RST    = 10'd30;
  localparam logic [TICK_W-1:0]   PWM_MAX_RST    = 10'd118;
  localparam logic [DZ_W-1:0]     DZ_LOW_RST     = 8'd1;
  localparam logic [DZ_W-1:0]     DZ_HIGH_RST    = 8'd2;
  localparam logic [SAMPLE_W-1:0] FAST_LIMIT_RST = 12'd50;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [TICK_W-1:0]   pwm_min;
    logic [TICK_W-1:0]   pwm_max;
    logic [DZ_W-1:0]     dz_low;
    logic [DZ_W-1:0]     dz_high;
    logic [SAMPLE_W-1:0] fast_limit;
    logic                byp_avg;
    logic                byp_dz;
  } cfg_t;

  // smoothed pair handed from the front to the back
  typedef struct packed {
    logic [SAMPLE_W-1:0] value_a;
    logic [SAMPLE_W-1:0] value_b;
  } mid_t;

  // one finished result
  typedef struct packed {
    logic                upd_a;
    logic [TICK_W-1:0]   ticks_a;
    logic                upd_b;
    logic [TICK_W-1:0]   ticks_b;
    logic [SAMPLE_W-1:0] avg_a;
    logic [SAMPLE_W-1:0] avg_b;
  } res_t;

endpackage

FILE: src/dual_pot_smooth_deadzone_servo_map_unit.sv
// Path: front stage register, middle queue, back stages 0 to 2, output queue, out_ ports.
// Throughput: one pair per clock while in_full is low; the front stage and the 4-entry middle
// queue set in_full. The 8-entry output queue keeps the back running while results wait
// to be popped. Reset (rst_n low, synchronous) empties both queues, clears ring valid bits,
// sums and reference values, and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// dual_pot_smooth_deadzone_servo_map_unit: dual pot smoother and servo mapper
// configuration registers, intake front, middle queue, deadband back end and
// output queue
// ----------------------------------------------------------------------------
module dual_pot_smooth_deadzone_servo_map_unit #(
  parameter int unsigned WINDOW_DEPTH   = 8,
  parameter int unsigned ADC_FULL_SCALE = 4000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [dpsdsm_pkg::SAMPLE_W-1:0]   in_sample_a,
  input  logic [dpsdsm_pkg::SAMPLE_W-1:0]   in_sample_b,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_update_a,
  output logic [dpsdsm_pkg::TICK_W-1:0]     out_ticks_a,
  output logic                              out_update_b,
  output logic [dpsdsm_pkg::TICK_W-1:0]     out_ticks_b,
  output logic [dpsdsm_pkg::SAMPLE_W-1:0]   out_average_a,
  output logic [dpsdsm_pkg::SAMPLE_W-1:0]   out_average_b,
  input  logic                              cfg_we,
  input  logic [dpsdsm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [dpsdsm_pkg::CFG_W-1:0]      cfg_data
);

  dpsdsm_pkg::cfg_t cfg_r, cfg_nxt;

  logic                              mid_push, mid_pop, mid_empty;
  dpsdsm_pkg::mid_t                  mid_wdata, mid_rdata;
  logic [dpsdsm_pkg::MID_CNT_W-1:0]  mid_count;
  logic                              res_push, res_pop;
  dpsdsm_pkg::res_t                  res_wdata, res_rdata;
  logic [dpsdsm_pkg::OUT_CNT_W-1:0]  res_count;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (dpsdsm_pkg::reg_idx_t'(cfg_index))
        dpsdsm_pkg::REG_PWM_MIN:    cfg_nxt.pwm_min    = cfg_data[dpsdsm_pkg::TICK_W-1:0];
        dpsdsm_pkg::REG_PWM_MAX:    cfg_nxt.pwm_max    = cfg_data[dpsdsm_pkg::TICK_W-1:0];
        dpsdsm_pkg::REG_DZ_LOW:     cfg_nxt.dz_low     = cfg_data[dpsdsm_pkg::DZ_W-1:0];
        dpsdsm_pkg::REG_DZ_HIGH:    cfg_nxt.dz_high    = cfg_data[dpsdsm_pkg::DZ_W-1:0];
        dpsdsm_pkg::REG_FAST_LIMIT: cfg_nxt.fast_limit = cfg_data[dpsdsm_pkg::SAMPLE_W-1:0];
        dpsdsm_pkg::REG_BYP_AVG:    cfg_nxt.byp_avg    = cfg_data[0];
        dpsdsm_pkg::REG_BYP_DZ:     cfg_nxt.byp_dz     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_min    <= dpsdsm_pkg::PWM_MIN_RST;
      cfg_r.pwm_max    <= dpsdsm_pkg::PWM_MAX_RST;
      cfg_r.dz_low     <= dpsdsm_pkg::DZ_LOW_RST;
      cfg_r.dz_high    <= dpsdsm_pkg::DZ_HIGH_RST;
      cfg_r.fast_limit <= dpsdsm_pkg::FAST_LIMIT_RST;
      cfg_r.byp_avg    <= 1'b0;
      cfg_r.byp_dz     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // intake and averaging
  dpsdsm_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_sample_a (in_sample_a),
    .in_sample_b (in_sample_b),
    .mid_count   (mid_count),
    .mid_push    (mid_push),
    .mid_data    (mid_wdata)
  );

  // queue between front and back
  dpsdsm_fifo #(
    .DEPTH (dpsdsm_pkg::MID_DEPTH),
    .WIDTH ($bits(dpsdsm_pkg::mid_t))
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count (mid_count)
  );

  // deadband and tick mapping
  dpsdsm_back #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_count (res_count),
    .out_push  (res_push),
    .out_data  (res_wdata)
  );

  // output queue; a transfer out happens on pop while not empty
  assign res_pop = out_pop && !out_empty;

  dpsdsm_fifo #(
    .DEPTH (dpsdsm_pkg::OUT_DEPTH),
    .WIDTH ($bits(dpsdsm_pkg::res_t))
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .pop   (res_pop),
    .rdata (res_rdata),
    .empty (out_empty),
    .count (res_count)
  );

  // result ports
  assign out_update_a  = res_rdata.upd_a;
  assign out_ticks_a   = res_rdata.ticks_a;
  assign out_update_b  = res_rdata.upd_b;
  assign out_ticks_b   = res_rdata.ticks_b;
  assign out_average_a = res_rdata.avg_a;
  assign out_average_b = res_rdata.avg_b;

endmodule

FILE: src/dpsdsm_fifo.sv
// ----------------------------------------------------------------------------
// dpsdsm_fifo: small register queue
// first-word-fall-through queue with an occupancy count for credit checks
// ----------------------------------------------------------------------------
module dpsdsm_fifo #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH + 1)-1:0]   count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = store_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  // no overflow and no transfer out of an empty queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> count_r != CNT_W'(DEPTH))
    else $error("queue overflow");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue underflow");

endmodule

FILE: src/dpsdsm_front.sv
// ----------------------------------------------------------------------------
// dpsdsm_front: sample intake and rolling average
// takes sample pairs, keeps the sample ring and running sums, and hands the
// averaged (or raw) pair to the middle queue through a stage register, in the cycle after it is taken and no later
// ----------------------------------------------------------------------------
module dpsdsm_front #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dpsdsm_pkg::cfg_t                    cfg,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [dpsdsm_pkg::SAMPLE_W-1:0]     in_sample_a,
  input  logic [dpsdsm_pkg::SAMPLE_W-1:0]     in_sample_b,
  input  logic [dpsdsm_pkg::MID_CNT_W-1:0]    mid_count,
  output logic                                mid_push,
  output dpsdsm_pkg::mid_t                    mid_data
);

  localparam int unsigned SW        = dpsdsm_pkg::SAMPLE_W;
  localparam int unsigned SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W     = SW + SLOT_W;
  localparam int unsigned REC_SHIFT = SUM_W + SLOT_W;
  localparam int unsigned AVG_PW    = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] REC_MULT = (SUM_W + 1)'(
    ((64'd1 << REC_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
  localparam int unsigned CW        = dpsdsm_pkg::MID_CNT_W;

  logic                   accept;
  logic [CW:0]            credit_used;
  logic [SLOT_W-1:0]      slot_r, slot_nxt, slot_inc, rd_addr;
  logic [WINDOW_DEPTH-1:0] vld_r, vld_nxt;
  logic [2*SW-1:0]        ring_mem [WINDOW_DEPTH];
  logic [2*SW-1:0]        rd_q_r;
  logic [SW-1:0]          old_a, old_b;
  logic [SUM_W-1:0]       sum_a_r, sum_a_nxt, sum_b_r, sum_b_nxt;
  logic                   f1_vld_r;
  logic [SW-1:0]          f1_raw_a_r, f1_raw_b_r;
  logic [SUM_W-1:0]       f1_sum_a_r, f1_sum_b_r;
  logic [AVG_PW-1:0]      prod_a, prod_b;
  logic [SW-1:0]          avg_a, avg_b;

  // credit check against the middle queue, counting the item in the stage
  assign credit_used = {1'b0, mid_count} + {{CW{1'b0}}, f1_vld_r};
  assign in_full     = credit_used >= (CW + 1)'(dpsdsm_pkg::MID_DEPTH);
  assign accept      = in_push && !in_full;

  // slot walk and read-ahead address
  assign slot_inc = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign rd_addr  = accept ? slot_inc : slot_r;

  // sample ring, read in the cycle before use
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[slot_r] <= {in_sample_a, in_sample_b};
    end
    rd_q_r <= ring_mem[rd_addr];
  end

  // a slot never written since reset counts as zero
  assign old_a = vld_r[slot_r] ? rd_q_r[2*SW-1:SW] : '0;
  assign old_b = vld_r[slot_r] ? rd_q_r[SW-1:0]    : '0;

  // running sums and slot state
  always_comb begin
    slot_nxt  = slot_r;
    vld_nxt   = vld_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (accept) begin
      slot_nxt         = slot_inc;
      vld_nxt[slot_r]  = 1'b1;
      sum_a_nxt        = sum_a_r - SUM_W'(old_a) + SUM_W'(in_sample_a);
      sum_b_nxt        = sum_b_r - SUM_W'(old_b) + SUM_W'(in_sample_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      vld_r    <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      f1_vld_r <= 1'b0;
    end else begin
      slot_r   <= slot_nxt;
      vld_r    <= vld_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      f1_vld_r <= accept;
    end
  end

  // stage register ahead of the average multiply
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_raw_a_r <= in_sample_a;
      f1_raw_b_r <= in_sample_b;
      f1_sum_a_r <= sum_a_nxt;
      f1_sum_b_r <= sum_b_nxt;
    end
  end

  // average through the reciprocal of the window depth
  assign prod_a = AVG_PW'(f1_sum_a_r) * AVG_PW'(REC_MULT);
  assign prod_b = AVG_PW'(f1_sum_b_r) * AVG_PW'(REC_MULT);
  assign avg_a  = SW'(prod_a >> REC_SHIFT);
  assign avg_b  = SW'(prod_b >> REC_SHIFT);

  // hand-off to the middle queue
  assign mid_push         = f1_vld_r;
  assign mid_data.value_a = cfg.byp_avg ? f1_raw_a_r : avg_a;
  assign mid_data.value_b = cfg.byp_avg ? f1_raw_b_r : avg_b;

  // queued plus staged items never exceed the middle queue
  a_mid_credit : assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= (CW + 1)'(dpsdsm_pkg::MID_DEPTH))
    else $error("middle queue credit exceeded");

  // the slot just written is marked as holding a sample
  a_slot_marked : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld_r[$past(slot_r)])
    else $error("ring slot not marked after write");

endmodule

FILE: src/dpsdsm_back.sv
// ----------------------------------------------------------------------------
// dpsdsm_back: deadband decision and servo tick mapping
// pulls smoothed pairs from the middle queue, decides per channel whether the
// value moves far enough to be taken, and scales it to servo ticks
// ----------------------------------------------------------------------------
module dpsdsm_back #(
  parameter int unsigned ADC_FULL_SCALE = 4000
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dpsdsm_pkg::cfg_t                  cfg,
  input  logic                              mid_empty,
  input  dpsdsm_pkg::mid_t                  mid_data,
  output logic                              mid_pop,
  input  logic [dpsdsm_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                              out_push,
  output dpsdsm_pkg::res_t                  out_data
);

  localparam int unsigned SW     = dpsdsm_pkg::SAMPLE_W;
  localparam int unsigned TW     = dpsdsm_pkg::TICK_W;
  localparam int unsigned PW     = dpsdsm_pkg::PROD_W;
  localparam int unsigned CW     = dpsdsm_pkg::OUT_CNT_W;
  localparam int unsigned FS_W   = $clog2(ADC_FULL_SCALE);
  localparam int unsigned TS     = PW + FS_W;
  localparam int unsigned SCL_PW = 2 * PW + 1;
  localparam logic [PW:0] TM = (PW + 1)'(
    ((64'd1 << TS) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE));
  localparam logic [SW-1:0] FS_VAL = SW'(ADC_FULL_SCALE);

  // deadband test of one channel against its last taken value
  function automatic logic take_value(
    input logic [SW-1:0]  value,
    input logic [SW-1:0]  held,
    input dpsdsm_pkg::cfg_t c
  );
    logic [SW-1:0]                        diff;
    logic [dpsdsm_pkg::DIV10_PROD_W-1:0]  prod;
    logic [dpsdsm_pkg::STEP_W-1:0]        step;
    logic [dpsdsm_pkg::DZ_W-1:0]          raw_band;
    logic [dpsdsm_pkg::DZ_W-1:0]          band;
    diff     = (value > held) ? value - held : held - value;
    prod     = dpsdsm_pkg::DIV10_PROD_W'(diff) *
               dpsdsm_pkg::DIV10_PROD_W'(dpsdsm_pkg::DIV10_MULT);
    step     = dpsdsm_pkg::STEP_W'(prod >> dpsdsm_pkg::DIV10_SHIFT);
    raw_band = c.dz_high - step[dpsdsm_pkg::DZ_W-1:0];
    priority if (diff > c.fast_limit) begin
      band = c.dz_low;
    end else if (step >= {1'b0, c.dz_high}) begin
      band = c.dz_low;
    end else if (raw_band < c.dz_low) begin
      band = c.dz_low;
    end else begin
      band = raw_band;
    end
    return c.byp_dz || (diff > SW'(band));
  endfunction

  // clip to the full-scale value
  function automatic logic [SW-1:0] clip_value(input logic [SW-1:0] value);
    return (value > FS_VAL) ? FS_VAL : value;
  endfunction

  logic           up_range;
  logic [TW-1:0]  span;
  logic [CW:0]    out_used;
  logic           upd_a_nxt, upd_b_nxt;

  logic           b0_vld_r, b1_vld_r, b2_vld_r;
  logic [SW-1:0]  b0_a_r, b0_b_r;
  logic [SW-1:0]  acc_a_r, acc_b_r;
  logic           b1_upd_a_r, b1_upd_b_r;
  logic [SW-1:0]  b1_a_r, b1_b_r;
  logic [PW-1:0]  b1_prod_a_r, b1_prod_b_r;
  logic           b2_upd_a_r, b2_upd_b_r;
  logic [SW-1:0]  b2_a_r, b2_b_r;
  logic [TW-1:0]  b2_q_a_r, b2_q_b_r;
  logic [SCL_PW-1:0] scl_a, scl_b;

  // tick range direction and size
  assign up_range = cfg.pwm_max >= cfg.pwm_min;
  assign span     = up_range ? cfg.pwm_max - cfg.pwm_min : cfg.pwm_min - cfg.pwm_max;

  // pull from the middle queue only with room downstream for the result
  assign out_used = {1'b0, out_count} + (CW + 1)'(b0_vld_r) + (CW + 1)'(b1_vld_r)
                  + (CW + 1)'(b2_vld_r);
  assign mid_pop  = !mid_empty && (out_used < (CW + 1)'(dpsdsm_pkg::OUT_DEPTH));

  // deadband decisions on the staged pair
  assign upd_a_nxt = take_value(b0_a_r, acc_a_r, cfg);
  assign upd_b_nxt = take_value(b0_b_r, acc_b_r, cfg);

  // stage valids and last taken values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r <= 1'b0;
      b1_vld_r <= 1'b0;
      b2_vld_r <= 1'b0;
      acc_a_r  <= '0;
      acc_b_r  <= '0;
    end else begin
      b0_vld_r <= mid_pop;
      b1_vld_r <= b0_vld_r;
      b2_vld_r <= b1_vld_r;
      if (b0_vld_r && upd_a_nxt) begin
        acc_a_r <= b0_a_r;
      end
      if (b0_vld_r && upd_b_nxt) begin
        acc_b_r <= b0_b_r;
      end
    end
  end

  // stage 0: pair from the middle queue
  always_ff @(posedge clk) begin
    if (mid_pop) begin
      b0_a_r <= mid_data.value_a;
      b0_b_r <= mid_data.value_b;
    end
  end

  // stage 1: decision flags and clip times span
  always_ff @(posedge clk) begin
    if (b0_vld_r) begin
      b1_upd_a_r  <= upd_a_nxt;
      b1_upd_b_r  <= upd_b_nxt;
      b1_a_r      <= b0_a_r;
      b1_b_r      <= b0_b_r;
      b1_prod_a_r <= PW'(clip_value(b0_a_r)) * PW'(span);
      b1_prod_b_r <= PW'(clip_value(b0_b_r)) * PW'(span);
    end
  end

  // stage 2: scale down by the full-scale value through its reciprocal
  assign scl_a = SCL_PW'(b1_prod_a_r) * SCL_PW'(TM);
  assign scl_b = SCL_PW'(b1_prod_b_r) * SCL_PW'(TM);

  always_ff @(posedge clk) begin
    if (b1_vld_r) begin
      b2_upd_a_r <= b1_upd_a_r;
      b2_upd_b_r <= b1_upd_b_r;
      b2_a_r     <= b1_a_r;
      b2_b_r     <= b1_b_r;
      b2_q_a_r   <= TW'(scl_a >> TS);
      b2_q_b_r   <= TW'(scl_b >> TS);
    end
  end

  // result assembly; ticks read zero without an update
  assign out_push         = b2_vld_r;
  assign out_data.upd_a   = b2_upd_a_r;
  assign out_data.upd_b   = b2_upd_b_r;
  assign out_data.ticks_a = !b2_upd_a_r ? '0 :
                            (up_range ? cfg.pwm_min + b2_q_a_r : cfg.pwm_min - b2_q_a_r);
  assign out_data.ticks_b = !b2_upd_b_r ? '0 :
                            (up_range ? cfg.pwm_min + b2_q_b_r : cfg.pwm_min - b2_q_b_r);
  assign out_data.avg_a   = b2_a_r;
  assign out_data.avg_b   = b2_b_r;

  // results in flight never exceed the output queue
  a_out_credit : assert property (@(posedge clk) disable iff (!rst_n)
    out_used <= (CW + 1)'(dpsdsm_pkg::OUT_DEPTH))
    else $error("output queue credit exceeded");

  // deadband bypass forces both channels to update
  a_bypass_updates : assert property (@(posedge clk) disable iff (!rst_n)
    b0_vld_r && cfg.byp_dz |=> b1_upd_a_r && b1_upd_b_r)
    else $error("deadband bypass without update");

  // a taken value on channel a becomes the new reference of that channel
  a_taken_held : assert property (@(posedge clk) disable iff (!rst_n)
    b1_vld_r && b1_upd_a_r |-> acc_a_r == b1_a_r)
    else $error("channel a reference not updated");

endmodule

FILE: tb/sv/dual_pot_smooth_deadzone_servo_map_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pot_smooth_deadzone_servo_map_unit_tb: self-checking bench of the servo map
// pushes sample pairs into the block in bursts, pops results on its own
// stall pattern and checks each one against a local copy of the smoothing,
// deadband and tick scaling, under several register settings
// ----------------------------------------------------------------------------
module dual_pot_smooth_deadzone_servo_map_unit_tb;

  localparam int unsigned WINDOW      = 8;
  localparam int unsigned FULL_SCALE  = 4000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [dpsdsm_pkg::IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [dpsdsm_pkg::SAMPLE_W-1:0] a;
    logic [dpsdsm_pkg::SAMPLE_W-1:0] b;
  } sample_pair_t;

  typedef enum int {WALK_JUMP, WALK_HOLD, WALK_DRIFT, WALK_RAIL} walk_mode_t;
  typedef enum int {POP_ALWAYS, POP_COIN, POP_RARE} pop_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] in_sample_a = '0;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] in_sample_b = '0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic                            out_update_a;
  logic [dpsdsm_pkg::TICK_W-1:0]   out_ticks_a;
  logic                            out_update_b;
  logic [dpsdsm_pkg::TICK_W-1:0]   out_ticks_b;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] out_average_a;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] out_average_b;
  logic                            cfg_we = 1'b0;
  logic [dpsdsm_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [dpsdsm_pkg::CFG_W-1:0]    cfg_data = '0;

  // pairs waiting to be offered, results waiting to be popped
  sample_pair_t      pending_pairs[$];
  dpsdsm_pkg::res_t  servo_results_due[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;

  // local copy of the block's registers and state
  dpsdsm_pkg::cfg_t                servo_cfg;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] window_a[WINDOW];
  logic [dpsdsm_pkg::SAMPLE_W-1:0] window_b[WINDOW];
  logic [14:0]                     total_a;
  logic [14:0]                     total_b;
  int unsigned                     window_slot;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] held_a;
  logic [dpsdsm_pkg::SAMPLE_W-1:0] held_b;

  always #4 clk = ~clk;

  dual_pot_smooth_deadzone_servo_map_unit #(
    .WINDOW_DEPTH  (WINDOW),
    .ADC_FULL_SCALE(FULL_SCALE)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_sample_a  (in_sample_a),
    .in_sample_b  (in_sample_b),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_update_a (out_update_a),
    .out_ticks_a  (out_ticks_a),
    .out_update_b (out_update_b),
    .out_ticks_b  (out_ticks_b),
    .out_average_a(out_average_a),
    .out_average_b(out_average_b),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned deadband_for(int unsigned diff);
    int unsigned step;
    if (diff > 32'(servo_cfg.fast_limit)) return 32'(servo_cfg.dz_low);
    step = diff / 10;
    if (step >= 32'(servo_cfg.dz_high)) return 32'(servo_cfg.dz_low);
    step = 32'(servo_cfg.dz_high) - step;
    return (step < 32'(servo_cfg.dz_low)) ? 32'(servo_cfg.dz_low) : step;
  endfunction

  function automatic logic [dpsdsm_pkg::TICK_W-1:0] ticks_for(int unsigned value);
    int unsigned clip;
    int unsigned t;
    int unsigned lo;
    int unsigned hi;
    lo = 32'(servo_cfg.pwm_min);
    hi = 32'(servo_cfg.pwm_max);
    clip = (value > FULL_SCALE) ? FULL_SCALE : value;
    if (hi >= lo)
      t = lo + clip * (hi - lo) / FULL_SCALE;
    else
      t = lo - clip * (lo - hi) / FULL_SCALE;
    return t[dpsdsm_pkg::TICK_W-1:0];
  endfunction

  // one channel: move the held value only when the change clears the deadband
  function automatic void servo_channel(input logic [dpsdsm_pkg::SAMPLE_W-1:0] value,
                                        inout logic [dpsdsm_pkg::SAMPLE_W-1:0] held,
                                        output logic upd,
                                        output logic [dpsdsm_pkg::TICK_W-1:0] ticks);
    int unsigned diff;
    diff = (value > held) ? 32'(value) - 32'(held) : 32'(held) - 32'(value);
    if (servo_cfg.byp_dz || diff > deadband_for(diff)) begin
      held  = value;
      upd   = 1'b1;
      ticks = ticks_for(32'(value));
    end else begin
      upd   = 1'b0;
      ticks = '0;
    end
  endfunction

  function automatic dpsdsm_pkg::res_t predict_servo_pair(
    logic [dpsdsm_pkg::SAMPLE_W-1:0] a,
    logic [dpsdsm_pkg::SAMPLE_W-1:0] b
  );
    dpsdsm_pkg::res_t r;
    total_a = total_a - 15'(window_a[window_slot]) + 15'(a);
    total_b = total_b - 15'(window_b[window_slot]) + 15'(b);
    window_a[window_slot] = a;
    window_b[window_slot] = b;
    window_slot = (window_slot + 1) % WINDOW;
    // the window keeps running under the average bypass
    if (servo_cfg.byp_avg) begin
      r.avg_a = a;
      r.avg_b = b;
    end else begin
      r.avg_a = dpsdsm_pkg::SAMPLE_W'(32'(total_a) / WINDOW);
      r.avg_b = dpsdsm_pkg::SAMPLE_W'(32'(total_b) / WINDOW);
    end
    servo_channel(r.avg_a, held_a, r.upd_a, r.ticks_a);
    servo_channel(r.avg_b, held_b, r.upd_b, r.ticks_b);
    return r;
  endfunction

  // ------------------------------------------------------------------- driver

  sample_pair_t next_pair;
  int           burst_left = 1;
  int           gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full)
        servo_results_due.push_back(predict_servo_pair(in_sample_a, in_sample_b));
      // an offered pair stays put until its transfer
      if (!(in_push && in_full)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_push <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          next_pair = pending_pairs.pop_front();
          in_sample_a <= next_pair.a;
          in_sample_b <= next_pair.b;
          in_push <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  int unsigned      results_seen = 0;
  int unsigned      hold_left = 0;
  int unsigned      stall_left = 0;
  pop_mode_t        pop_mode = POP_ALWAYS;
  dpsdsm_pkg::res_t due;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (servo_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no pair behind it, average_a %0d average_b %0d",
                   $time, out_average_a, out_average_b);
        end else begin
          due = servo_results_due.pop_front();
          check_field("update_a", 32'(due.upd_a), 32'(out_update_a));
          check_field("ticks_a", 32'(due.ticks_a), 32'(out_ticks_a));
          check_field("update_b", 32'(due.upd_b), 32'(out_update_b));
          check_field("ticks_b", 32'(due.ticks_b), 32'(out_ticks_b));
          check_field("average_a", 32'(due.avg_a), 32'(out_average_a));
          check_field("average_b", 32'(due.avg_b), 32'(out_average_b));
        end
        results_seen++;
        // long hold-off so the queues fill and the input backs up
        if (results_seen == 100 || results_seen == 500) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          pop_mode = pop_mode_t'($urandom_range(0, 2));
          stall_left = $urandom_range(8, 60);
        end else begin
          stall_left--;
        end
        unique case (pop_mode)
          POP_ALWAYS: out_pop <= 1'b1;
          POP_COIN:   out_pop <= 1'($urandom_range(0, 1));
          default:    out_pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------ timeout

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic write_reg(input logic [dpsdsm_pkg::IDX_W-1:0] idx,
                           input logic [dpsdsm_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // mirror the write, masked to the register width
    unique case (idx)
      dpsdsm_pkg::REG_PWM_MIN:    servo_cfg.pwm_min    = value[dpsdsm_pkg::TICK_W-1:0];
      dpsdsm_pkg::REG_PWM_MAX:    servo_cfg.pwm_max    = value[dpsdsm_pkg::TICK_W-1:0];
      dpsdsm_pkg::REG_DZ_LOW:     servo_cfg.dz_low     = value[dpsdsm_pkg::DZ_W-1:0];
      dpsdsm_pkg::REG_DZ_HIGH:    servo_cfg.dz_high    = value[dpsdsm_pkg::DZ_W-1:0];
      dpsdsm_pkg::REG_FAST_LIMIT: servo_cfg.fast_limit = value[dpsdsm_pkg::SAMPLE_W-1:0];
      dpsdsm_pkg::REG_BYP_AVG:    servo_cfg.byp_avg    = value[0];
      dpsdsm_pkg::REG_BYP_DZ:     servo_cfg.byp_dz     = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic add_pair(input logic [dpsdsm_pkg::SAMPLE_W-1:0] a,
                          input logic [dpsdsm_pkg::SAMPLE_W-1:0] b);
    pending_pairs.push_back('{a: a, b: b});
  endtask

  // wait until every offered pair has come back out
  task automatic wait_idle();
    while (pending_pairs.size() != 0 || in_push || servo_results_due.size() != 0)
      @(negedge clk);
  endtask

  function automatic int next_level(int level, walk_mode_t mode);
    unique case (mode)
      WALK_JUMP:  return $urandom_range(0, 4095);
      WALK_HOLD:  level += int'($urandom_range(0, 2)) - 1;
      WALK_DRIFT: level += int'($urandom_range(0, 80)) - 40;
      default:    return ($urandom_range(0, 1) == 1) ? 4095 : 0;
    endcase
    if (level < 0) return 0;
    if (level > 4095) return 4095;
    return level;
  endfunction

  // pot traces: runs of jumps, steady holds, slow drifts and rail hits
  task automatic queue_random_pairs(input int unsigned count);
    int         level_a;
    int         level_b;
    int         run;
    walk_mode_t mode;
    level_a = $urandom_range(0, 4095);
    level_b = $urandom_range(0, 4095);
    run = 0;
    mode = WALK_JUMP;
    repeat (count) begin
      if (run == 0) begin
        mode = walk_mode_t'($urandom_range(0, 3));
        run = $urandom_range(4, 40);
      end
      run--;
      level_a = next_level(level_a, mode);
      level_b = next_level(level_b, mode);
      add_pair(level_a[dpsdsm_pkg::SAMPLE_W-1:0], level_b[dpsdsm_pkg::SAMPLE_W-1:0]);
    end
  endtask

  task automatic random_settings();
    write_reg(dpsdsm_pkg::REG_PWM_MIN, dpsdsm_pkg::CFG_W'($urandom_range(0, 999)));
    write_reg(dpsdsm_pkg::REG_PWM_MAX, dpsdsm_pkg::CFG_W'($urandom_range(0, 999)));
    write_reg(dpsdsm_pkg::REG_DZ_LOW, dpsdsm_pkg::CFG_W'($urandom_range(0, 255)));
    write_reg(dpsdsm_pkg::REG_DZ_HIGH, dpsdsm_pkg::CFG_W'($urandom_range(0, 255)));
    write_reg(dpsdsm_pkg::REG_FAST_LIMIT, dpsdsm_pkg::CFG_W'($urandom_range(0, 4095)));
    write_reg(dpsdsm_pkg::REG_BYP_AVG, dpsdsm_pkg::CFG_W'($urandom_range(0, 3) == 0));
    write_reg(dpsdsm_pkg::REG_BYP_DZ, dpsdsm_pkg::CFG_W'($urandom_range(0, 4) == 0));
  endtask

  initial begin
    // reset state of the local copy
    servo_cfg = '{pwm_min: dpsdsm_pkg::PWM_MIN_RST, pwm_max: dpsdsm_pkg::PWM_MAX_RST,
                  dz_low: dpsdsm_pkg::DZ_LOW_RST, dz_high: dpsdsm_pkg::DZ_HIGH_RST,
                  fast_limit: dpsdsm_pkg::FAST_LIMIT_RST,
                  byp_avg: 1'b0, byp_dz: 1'b0};
    foreach (window_a[i]) begin
      window_a[i] = '0;
      window_b[i] = '0;
    end
    total_a = '0;
    total_b = '0;
    window_slot = 0;
    held_a = '0;
    held_b = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: no change, a full window of top values, rails crossed
    add_pair(12'd0, 12'd0);
    add_pair(12'd0, 12'd0);
    repeat (9) add_pair(12'd4095, 12'd4095);
    add_pair(12'd0, 12'd4095);
    add_pair(12'd4095, 12'd0);
    add_pair(12'd2048, 12'd1);
    wait_idle();

    // reversed tick range, low deadband above high, raw samples, dead index
    write_reg(dpsdsm_pkg::REG_PWM_MIN, 12'd999);
    write_reg(dpsdsm_pkg::REG_PWM_MAX, 12'd0);
    write_reg(dpsdsm_pkg::REG_DZ_LOW, 12'd200);
    write_reg(dpsdsm_pkg::REG_DZ_HIGH, 12'd5);
    write_reg(dpsdsm_pkg::REG_FAST_LIMIT, 12'd4095);
    write_reg(dpsdsm_pkg::REG_BYP_AVG, 12'hFFF);
    write_reg(REG_NONE, 12'h5A5);
    add_pair(12'd0, 12'd4095);
    add_pair(12'd4095, 12'd0);
    add_pair(12'd4000, 12'd4001);
    add_pair(12'd3900, 12'd3999);
    add_pair(12'd3700, 12'd100);
    add_pair(12'd0, 12'd0);
    wait_idle();

    // deadband bypass, wide data masked down to each register
    write_reg(dpsdsm_pkg::REG_BYP_DZ, 12'hFFF);
    write_reg(dpsdsm_pkg::REG_BYP_AVG, 12'hFFE);
    write_reg(dpsdsm_pkg::REG_PWM_MIN, 12'hFE7);
    write_reg(dpsdsm_pkg::REG_PWM_MAX, 12'h400);
    write_reg(dpsdsm_pkg::REG_DZ_LOW, 12'hF00);
    add_pair(12'd1234, 12'd4095);
    add_pair(12'd1234, 12'd4095);
    add_pair(12'd4095, 12'd0);
    add_pair(12'd0, 12'd2730);
    add_pair(12'd2730, 12'd0);
    wait_idle();

    // back to the reset settings
    write_reg(dpsdsm_pkg::REG_PWM_MIN, dpsdsm_pkg::CFG_W'(dpsdsm_pkg::PWM_MIN_RST));
    write_reg(dpsdsm_pkg::REG_PWM_MAX, dpsdsm_pkg::CFG_W'(dpsdsm_pkg::PWM_MAX_RST));
    write_reg(dpsdsm_pkg::REG_DZ_LOW, dpsdsm_pkg::CFG_W'(dpsdsm_pkg::DZ_LOW_RST));
    write_reg(dpsdsm_pkg::REG_DZ_HIGH, dpsdsm_pkg::CFG_W'(dpsdsm_pkg::DZ_HIGH_RST));
    write_reg(dpsdsm_pkg::REG_FAST_LIMIT, dpsdsm_pkg::CFG_W'(dpsdsm_pkg::FAST_LIMIT_RST));
    write_reg(dpsdsm_pkg::REG_BYP_AVG, 12'd0);
    write_reg(dpsdsm_pkg::REG_BYP_DZ, 12'd0);
    queue_random_pairs(200);
    wait_idle();

    // full tick span, widest deadband, fast limit out of reach
    write_reg(dpsdsm_pkg::REG_PWM_MIN, 12'd0);
    write_reg(dpsdsm_pkg::REG_PWM_MAX, 12'd999);
    write_reg(dpsdsm_pkg::REG_DZ_LOW, 12'd0);
    write_reg(dpsdsm_pkg::REG_DZ_HIGH, 12'd255);
    write_reg(dpsdsm_pkg::REG_FAST_LIMIT, 12'd4095);
    queue_random_pairs(150);
    wait_idle();

    repeat (3) begin
      random_settings();
      queue_random_pairs(100);
      wait_idle();
    end

    // top of both deadband widths, fast limit at zero, reversed full span
    write_reg(dpsdsm_pkg::REG_PWM_MIN, 12'd999);
    write_reg(dpsdsm_pkg::REG_PWM_MAX, 12'd0);
    write_reg(dpsdsm_pkg::REG_DZ_LOW, 12'd255);
    write_reg(dpsdsm_pkg::REG_DZ_HIGH, 12'd255);
    write_reg(dpsdsm_pkg::REG_FAST_LIMIT, 12'd0);
    write_reg(dpsdsm_pkg::REG_BYP_AVG, 12'd0);
    write_reg(dpsdsm_pkg::REG_BYP_DZ, 12'd0);
    queue_random_pairs(100);
    wait_idle();

    // let any stray result show up before the verdict
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatch_count == 0 && servo_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
